>>> design/tlvd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvd_pkg
// Shared types and constants for the tag-length-value field deframer.
// ----------------------------------------------------------------------------
package tlvd_pkg;

  localparam int unsigned HdrCountW = 3;
  localparam logic [HdrCountW-1:0] HeaderBytes = 3'd6;

  // tag whose data carries the override length
  localparam logic [31:0] TagOverride = 32'h5858_5858;

  localparam int unsigned CaptureW = 3;
  localparam logic [CaptureW-1:0] CaptureBytes = 3'd4;

  typedef struct packed {
    logic [31:0] field_tag;
    logic [31:0] field_length;
    logic [31:0] byte_offset;
    logic [7:0]  byte_value;
    logic        in_header;
    logic        field_done;
    logic        truncated;
  } tlvd_result_t;

endpackage

>>> design/tlvd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvd_core
// Per-word parse state and the single-pass update that yields one result
// for each accepted word.
// ----------------------------------------------------------------------------
module tlvd_core
  import tlvd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   data_byte_i,
  input  logic         record_last_i,
  output tlvd_result_t res_o
);

  logic [HdrCountW-1:0] count_q, count_d;
  logic [39:0]          shift_q, shift_d;
  logic [31:0]          remaining_q, remaining_d;
  logic [31:0]          offset_q, offset_d;
  logic [31:0]          length_q, length_d;
  logic [31:0]          override_q, override_d;
  logic [CaptureW-1:0]  capture_q, capture_d;

  logic [15:0] raw_len;
  logic [31:0] eff_len;
  logic [31:0] hdr_tag;
  logic [1:0]  lane;

  always_comb begin
    count_d     = count_q;
    shift_d     = shift_q;
    remaining_d = remaining_q;
    offset_d    = offset_q;
    length_d    = length_q;
    override_d  = override_q;
    capture_d   = capture_q;

    // shift holds header bytes one to five, oldest on top
    hdr_tag = shift_q[39:8];
    raw_len = {data_byte_i, shift_q[7:0]};
    eff_len = (raw_len != 16'd0) ? {16'd0, raw_len} : override_q;
    lane    = 2'(CaptureBytes - capture_q);

    res_o              = '0;
    res_o.byte_value   = data_byte_i;

    if (count_q != HeaderBytes) begin
      res_o.in_header = 1'b1;
      if (count_q == HeaderBytes - 3'd1) begin
        res_o.field_tag    = hdr_tag;
        res_o.field_length = eff_len;
        remaining_d        = eff_len;
        offset_d           = '0;
        length_d           = eff_len;
        count_d            = HeaderBytes;
        if (hdr_tag == TagOverride) begin
          override_d = '0;
          capture_d  = (eff_len != 32'd0) ? CaptureBytes : '0;
        end
        if (eff_len == 32'd0) begin
          res_o.field_done = 1'b1;
          count_d          = '0;
          capture_d        = '0;
        end
      end else begin
        shift_d = {shift_q[31:0], data_byte_i};
        count_d = count_q + 3'd1;
      end
    end else begin
      res_o.field_tag    = hdr_tag;
      res_o.field_length = length_q;
      res_o.byte_offset  = offset_q;
      if (capture_q != '0) begin
        override_d[8*lane +: 8] = data_byte_i;
        capture_d               = capture_q - 3'd1;
      end
      offset_d = offset_q + 32'd1;
      if (remaining_q <= 32'd1) begin
        res_o.field_done = 1'b1;
        remaining_d      = '0;
        count_d          = '0;
        capture_d        = '0;
      end else begin
        remaining_d = remaining_q - 32'd1;
      end
    end

    if (record_last_i) begin
      res_o.truncated = (count_d != '0);
      count_d     = '0;
      shift_d     = '0;
      remaining_d = '0;
      offset_d    = '0;
      length_d    = '0;
      override_d  = '0;
      capture_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      shift_q     <= '0;
      remaining_q <= '0;
      offset_q    <= '0;
      length_q    <= '0;
      override_q  <= '0;
      capture_q   <= '0;
    end else if (step_i) begin
      count_q     <= count_d;
      shift_q     <= shift_d;
      remaining_q <= remaining_d;
      offset_q    <= offset_d;
      length_q    <= length_d;
      override_q  <= override_d;
      capture_q   <= capture_d;
    end
  end

endmodule

>>> design/tlvd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvd_out_reg
// Result register with valid/ready; reloads in the cycle its word is taken.
// ----------------------------------------------------------------------------
module tlvd_out_reg
  import tlvd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  tlvd_result_t res_i,
  input  logic         out_ready_i,
  output logic         ready_o,
  output logic         out_valid_o,
  output tlvd_result_t res_o
);

  logic         valid_q, valid_d;
  tlvd_result_t res_q;

  assign ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> design/tlv_subrecord_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlv_subrecord_deframer
// Splits a record's field area, one byte per word, into tagged fields.
// ----------------------------------------------------------------------------
// Takes one byte per clock while the output is not stalled, and returns one
// result word per byte, valid in the cycle after acceptance. Throughput is
// one word per cycle when unstalled: the parse state updates combinationally
// and the result register reloads in the same cycle its word is taken.
// Each field has a six-byte header (four tag characters, then a 16-bit
// little-endian length); a zero length picks up the override taken from the
// first four data bytes of the latest XXXX field. All state clears after the
// word marked record_last_i, flagging truncated_o if a field was left open.
module tlv_subrecord_deframer
  import tlvd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        record_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] field_tag_o,
  output logic [31:0] field_length_o,
  output logic [31:0] byte_offset_o,
  output logic [7:0]  byte_value_o,
  output logic        in_header_o,
  output logic        field_done_o,
  output logic        truncated_o
);

  logic         step;
  tlvd_result_t step_res;
  tlvd_result_t out_res;

  assign step = in_valid_i && in_ready_o;

  tlvd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .data_byte_i   (data_byte_i),
    .record_last_i (record_last_i),
    .res_o         (step_res)
  );

  tlvd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (step_res),
    .out_ready_i (out_ready_i),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign field_tag_o    = out_res.field_tag;
  assign field_length_o = out_res.field_length;
  assign byte_offset_o  = out_res.byte_offset;
  assign byte_value_o   = out_res.byte_value;
  assign in_header_o    = out_res.in_header;
  assign field_done_o   = out_res.field_done;
  assign truncated_o    = out_res.truncated;

endmodule

>>> test/tlv_subrecord_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlv_subrecord_deframer_tb
// Self-checking bench for the tag-length-value field deframer.
// ----------------------------------------------------------------------------
// A short directed table is sent first: a zero-length field, an XXXX override,
// an override-length field cut short, and a record cut inside its header.
// After that come random records, mostly well formed with random tags,
// lengths and override values, plus some noise and some cut short. Every
// accepted byte is run through a local parse model. The expected result word
// joins a queue, and each word taken from the block is checked against the
// head of that queue. The sender works in bursts and the receiver stalls on a
// pattern that changes mode from time to time.
// ----------------------------------------------------------------------------
module tlv_subrecord_deframer_tb;
  import tlvd_pkg::*;

  localparam int unsigned RandomBytes = 1850;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 10;

  typedef struct packed {
    logic [7:0]   data;
    logic         rec_last;
    logic         fixed;
    tlvd_result_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        record_last_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] field_tag_o;
  logic [31:0] field_length_o;
  logic [31:0] byte_offset_o;
  logic [7:0]  byte_value_o;
  logic        in_header_o;
  logic        field_done_o;
  logic        truncated_o;

  tlv_subrecord_deframer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .record_last_i  (record_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .field_tag_o    (field_tag_o),
    .field_length_o (field_length_o),
    .byte_offset_o  (byte_offset_o),
    .byte_value_o   (byte_value_o),
    .in_header_o    (in_header_o),
    .field_done_o   (field_done_o),
    .truncated_o    (truncated_o)
  );

  always #5 clk_i = ~clk_i;

  // local copy of the parse state
  logic [2:0]  hdr_cnt;
  logic [47:0] hdr_sr;
  logic [31:0] data_left;
  logic [31:0] data_pos;
  logic [31:0] len_ovr;
  logic [2:0]  ovr_pending;

  tlvd_result_t pending_words[$];
  stim_row_t    byte_stream[$];
  stim_row_t    directed_rows[23];
  int unsigned  mismatch_count = 0;
  int unsigned  idle_cycles = 0;

  function automatic void clear_parse_state();
    hdr_cnt     = '0;
    hdr_sr      = '0;
    data_left   = '0;
    data_pos    = '0;
    len_ovr     = '0;
    ovr_pending = '0;
  endfunction

  function automatic tlvd_result_t parse_byte(logic [7:0] b, logic rec_last);
    tlvd_result_t r;
    logic [15:0]  raw;
    logic [1:0]   idx;
    r = '0;
    r.byte_value = b;
    if (hdr_cnt < HeaderBytes) begin
      r.in_header = 1'b1;
      hdr_sr  = {hdr_sr[39:0], b};
      hdr_cnt = hdr_cnt + 3'd1;
      if (hdr_cnt == HeaderBytes) begin
        raw = {hdr_sr[7:0], hdr_sr[15:8]};
        r.field_tag    = hdr_sr[47:16];
        r.field_length = (raw != '0) ? 32'(raw) : len_ovr;
        data_left = r.field_length;
        data_pos  = '0;
        // XXXX field keeps the old length but restarts the override
        if (r.field_tag == TagOverride) begin
          len_ovr     = '0;
          ovr_pending = (r.field_length != '0) ? CaptureBytes : '0;
        end
        if (r.field_length == '0) begin
          r.field_done = 1'b1;
          hdr_cnt      = '0;
          ovr_pending  = '0;
        end
      end
    end else begin
      r.field_tag    = hdr_sr[47:16];
      r.field_length = data_pos + data_left;
      r.byte_offset  = data_pos;
      if (ovr_pending != '0) begin
        idx = 2'(CaptureBytes - ovr_pending);
        len_ovr = len_ovr | (32'(b) << (8 * idx));
        ovr_pending = ovr_pending - 3'd1;
      end
      data_pos = data_pos + 32'd1;
      if (data_left <= 32'd1) begin
        data_left    = '0;
        r.field_done = 1'b1;
        hdr_cnt      = '0;
        ovr_pending  = '0;
      end else begin
        data_left = data_left - 32'd1;
      end
    end
    if (rec_last) begin
      r.truncated = (hdr_cnt != '0);
      clear_parse_state();
    end
    return r;
  endfunction

  function automatic tlvd_result_t mk_word(logic [31:0] tag, logic [31:0] len,
                                           logic [31:0] off, logic [7:0] b,
                                           logic hdr, logic done, logic trunc);
    tlvd_result_t r;
    r.field_tag    = tag;
    r.field_length = len;
    r.byte_offset  = off;
    r.byte_value   = b;
    r.in_header    = hdr;
    r.field_done   = done;
    r.truncated    = trunc;
    return r;
  endfunction

  // Mostly well-formed records; some pure noise, some cut at a random byte.
  task automatic build_record();
    logic [7:0]  rec[$];
    logic [31:0] tag;
    logic [31:0] ovr;
    logic [31:0] eff;
    logic [31:0] new_ovr;
    logic [15:0] raw;
    int          nfields;
    int          n_send;
    int          cut;
    bit          is_ovr;
    bit          ended;
    stim_row_t   row;
    ovr     = '0;
    new_ovr = '0;
    ended   = 1'b0;
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 10)) rec.insert(rec.size(), 8'($urandom));
    end else begin
      nfields = $urandom_range(1, 4);
      for (int f = 0; f < nfields && !ended; f++) begin
        is_ovr = ($urandom_range(0, 3) == 0);
        tag = is_ovr ? TagOverride : $urandom;
        case ($urandom_range(0, 9))
          0, 1:    raw = '0;
          9:       raw = 16'($urandom_range(9, 16'hFFFF));
          default: raw = 16'($urandom_range(1, 8));
        endcase
        eff = (raw != '0) ? 32'(raw) : ovr;
        for (int i = 3; i >= 0; i--) rec.insert(rec.size(), tag[8*i +: 8]);
        rec.insert(rec.size(), raw[7:0]);
        rec.insert(rec.size(), raw[15:8]);
        if (is_ovr) begin
          new_ovr = ($urandom_range(0, 4) == 0) ? $urandom : 32'($urandom_range(0, 10));
          ovr = '0;
        end
        // long fields are cut off by the record end after a few data bytes
        ended  = (eff > 32'd16);
        n_send = ended ? $urandom_range(0, 6) : int'(eff);
        for (int i = 0; i < n_send; i++) begin
          if (is_ovr && i < 4) begin
            rec.insert(rec.size(), new_ovr[8*i +: 8]);
            ovr[8*i +: 8] = new_ovr[8*i +: 8];
          end else begin
            rec.insert(rec.size(), 8'($urandom));
          end
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, rec.size());
        while (rec.size() > cut) rec.delete(rec.size() - 1);
      end
    end
    foreach (rec[i]) begin
      row = '0;
      row.data = rec[i];
      row.rec_last = (i == rec.size() - 1);
      byte_stream.insert(byte_stream.size(), row);
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_word(tlvd_result_t got, tlvd_result_t want);
    if (got.field_tag !== want.field_tag)
      report_mismatch("field_tag", got.field_tag, want.field_tag);
    if (got.field_length !== want.field_length)
      report_mismatch("field_length", got.field_length, want.field_length);
    if (got.byte_offset !== want.byte_offset)
      report_mismatch("byte_offset", got.byte_offset, want.byte_offset);
    if (got.byte_value !== want.byte_value)
      report_mismatch("byte_value", 32'(got.byte_value), 32'(want.byte_value));
    if (got.in_header !== want.in_header)
      report_mismatch("in_header", 32'(got.in_header), 32'(want.in_header));
    if (got.field_done !== want.field_done)
      report_mismatch("field_done", 32'(got.field_done), 32'(want.field_done));
    if (got.truncated !== want.truncated)
      report_mismatch("truncated", 32'(got.truncated), 32'(want.truncated));
  endtask

  // sender: bursts with random gaps, prediction on each accepted word
  initial begin
    stim_row_t    cur;
    tlvd_result_t predicted;
    int           burst_left;
    int           gap;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    data_byte_i   = '0;
    record_last_i = 1'b0;
    clear_parse_state();

    directed_rows = '{
      // zero length, no override in force, record ends on the last header byte
      '{8'h41, 1'b0, 1'b1, mk_word(32'h0, 32'h0, 32'h0, 8'h41, 1'b1, 1'b0, 1'b0)},
      '{8'h42, 1'b0, 1'b1, mk_word(32'h0, 32'h0, 32'h0, 8'h42, 1'b1, 1'b0, 1'b0)},
      '{8'h43, 1'b0, 1'b1, mk_word(32'h0, 32'h0, 32'h0, 8'h43, 1'b1, 1'b0, 1'b0)},
      '{8'h44, 1'b0, 1'b1, mk_word(32'h0, 32'h0, 32'h0, 8'h44, 1'b1, 1'b0, 1'b0)},
      '{8'h00, 1'b0, 1'b1, mk_word(32'h0, 32'h0, 32'h0, 8'h00, 1'b1, 1'b0, 1'b0)},
      '{8'h00, 1'b1, 1'b1,
        mk_word(32'h4142_4344, 32'h0, 32'h0, 8'h00, 1'b1, 1'b1, 1'b0)},
      // short XXXX field: override becomes 2
      '{8'h58, 1'b0, 1'b0, '0},
      '{8'h58, 1'b0, 1'b0, '0},
      '{8'h58, 1'b0, 1'b0, '0},
      '{8'h58, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      // raw length zero takes the override, record ends mid data
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b1,
        mk_word(32'hFF00_FF00, 32'h2, 32'h0, 8'hFF, 1'b0, 1'b0, 1'b1)},
      // record ends inside a header
      '{8'h7F, 1'b0, 1'b1, mk_word(32'h0, 32'h0, 32'h0, 8'h7F, 1'b1, 1'b0, 1'b0)},
      '{8'h80, 1'b1, 1'b1, mk_word(32'h0, 32'h0, 32'h0, 8'h80, 1'b1, 1'b0, 1'b1)}
    };
    foreach (directed_rows[i]) byte_stream.insert(byte_stream.size(), directed_rows[i]);
    while (byte_stream.size() < $size(directed_rows) + RandomBytes) build_record();

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    burst_left = 0;
    foreach (byte_stream[idx]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      cur = byte_stream[idx];
      data_byte_i   <= cur.data;
      record_last_i <= cur.rec_last;
      in_valid_i    <= 1'b1;
      do @(posedge clk_i); while (!in_ready_o);
      predicted = parse_byte(cur.data, cur.rec_last);
      pending_words.insert(pending_words.size(), cur.fixed ? cur.want : predicted);
      burst_left--;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver: stall mode is re-picked at random each time the phase wraps
  initial begin
    int unsigned mode;
    int unsigned phase;
    out_ready_i = 1'b0;
    mode  = 0;
    phase = 0;
    forever begin
      @(negedge clk_i);
      if (phase == 0) mode = $urandom_range(0, 3);
      phase = (phase + 1) % 64;
      case (mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= phase[0];
      endcase
    end
  end

  always @(posedge clk_i) begin
    tlvd_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {field_tag_o, field_length_o, byte_offset_o, byte_value_o,
             in_header_o, field_done_o, truncated_o};
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word, field_tag", got.field_tag, 32'h0);
      end else begin
        check_word(got, pending_words.pop_front());
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule
